// ===== rtl/spt_pkg.sv =====
// shared types and constants for the session pair table
// no dependencies
package spt_pkg;

	localparam int MAX_SESSIONS = 64;
	localparam int ID_W         = $clog2(MAX_SESSIONS);
	localparam int CNT_W        = ID_W + 1;
	localparam int FD_W         = 16;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_PAIR = 2'd2,
		OP_FIND = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BADARG   = 3'd1,
		ST_FULL     = 3'd2,
		ST_INUSE    = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_CONFLICT = 3'd5
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic cmp;
		logic enc;
		logic dec;
	} spt_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic out_busy;
	} spt_sts_t;

endpackage

// ===== rtl/spt_req_if.sv =====
// request channel: valid, ready and the request fields
// depends on spt_pkg
interface spt_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic [spt_pkg::FD_W-1:0] client_fd;
	logic                     client_present;
	logic [spt_pkg::FD_W-1:0] server_fd;
	logic                     server_present;
	logic [spt_pkg::ID_W-1:0] session_id;

	modport source (output valid, opcode, client_fd, client_present, server_fd,
		server_present, session_id, input ready);
	modport sink (input valid, opcode, client_fd, client_present, server_fd,
		server_present, session_id, output ready);
endinterface

// ===== rtl/spt_rsp_if.sv =====
// response channel: valid, ready and the result fields
// depends on spt_pkg
interface spt_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [2:0]                status;
	logic [spt_pkg::ID_W-1:0]  result_id;
	logic [spt_pkg::FD_W-1:0]  result_client_fd;
	logic                      result_client_present;
	logic [spt_pkg::FD_W-1:0]  result_server_fd;
	logic                      result_server_present;
	logic [spt_pkg::CNT_W-1:0] entries_used;

	modport source (output valid, status, result_id, result_client_fd,
		result_client_present, result_server_fd, result_server_present,
		entries_used, input ready);
	modport sink (input valid, status, result_id, result_client_fd,
		result_client_present, result_server_fd, result_server_present,
		entries_used, output ready);
endinterface

// ===== rtl/spt_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module spt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/spt_ctrl.sv =====
// controller state machine sequencing compare, encode and decide steps
// depends on spt_pkg
module spt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spt_pkg::spt_sts_t sts,
	output spt_pkg::spt_cmd_t cmd
);
	import spt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_ENC  = 4'b0100,
		S_DEC  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_CMP;
			S_CMP:  state_d = S_ENC;
			S_ENC:  state_d = S_DEC;
			S_DEC:  if (!sts.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign cmd.load = in_ready && in_valid;
	assign cmd.cmp  = (state_q == S_CMP);
	assign cmd.enc  = (state_q == S_ENC);
	assign cmd.dec  = (state_q == S_DEC) && !sts.out_busy;

	a_dec_after_enc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enc |=> state_q == S_DEC) else $error("decide step skipped");
	a_load_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.cmp) else $error("compare step skipped");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp |-> !in_ready) else $error("ready while busy");
endmodule

// ===== rtl/spt_datapath.sv =====
// session table storage, handle compare, id search, decision and result register
// depends on spt_pkg and spt_ram
module spt_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [spt_pkg::CNT_W-1:0] cfg_wdata,
	input  spt_pkg::spt_cmd_t         cmd,
	output spt_pkg::spt_sts_t         sts,
	input  logic [1:0]                in_opcode,
	input  logic [spt_pkg::FD_W-1:0]  in_client_fd,
	input  logic                      in_client_present,
	input  logic [spt_pkg::FD_W-1:0]  in_server_fd,
	input  logic                      in_server_present,
	input  logic [spt_pkg::ID_W-1:0]  in_session_id,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                out_status,
	output logic [spt_pkg::ID_W-1:0]  out_id,
	output logic [spt_pkg::FD_W-1:0]  out_client_fd,
	output logic                      out_client_present,
	output logic [spt_pkg::FD_W-1:0]  out_server_fd,
	output logic                      out_server_present,
	output logic [spt_pkg::CNT_W-1:0] out_used
);
	import spt_pkg::*;

	localparam int N = MAX_SESSIONS;

	// configuration and table state
	logic [CNT_W-1:0] tsize_q;
	logic [N-1:0]     val_q, ch_q, sh_q;
	logic [FD_W-1:0]  cfdm_q [N];
	logic [FD_W-1:0]  sfdm_q [N];
	logic [ID_W-1:0]  hint_q;
	logic [CNT_W-1:0] used_q;

	// latched request
	op_t              op_q;
	logic [FD_W-1:0]  cfd_q, sfd_q;
	logic             cp_q, sp_q;
	logic [ID_W-1:0]  sid_q;
	logic [CNT_W-1:0] size_q;

	// compare stage
	logic [N-1:0]     mc_s1, ms_s1, fr_s1;
	logic [ID_W-1:0]  start_s1;

	// encode stage
	logic             hc_s2, hs_s2, ff_s2;
	logic [ID_W-1:0]  cid_s2, vid_s2, fid_s2;

	// ram for read-back of handles, {server, client}
	logic             ram_we;
	logic [ID_W-1:0]  ram_waddr, ram_raddr;
	logic [2*FD_W-1:0] ram_wdata, ram_rdata;

	// output register
	logic             ov_q;
	status_t          ost_q;
	logic [ID_W-1:0]  oid_q;
	logic [FD_W-1:0]  ocfd_q, osfd_q;
	logic             ocp_q, osp_q;

	// effective size
	logic [CNT_W-1:0] eff_size;
	always_comb begin
		priority if (tsize_q == '0) eff_size = CNT_W'(1);
		else if (tsize_q > CNT_W'(N)) eff_size = CNT_W'(N);
		else eff_size = tsize_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= CNT_W'(N);
		end else if (cfg_we) begin
			tsize_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(in_opcode);
			cfd_q  <= in_client_fd;
			cp_q   <= in_client_present;
			sfd_q  <= in_server_fd;
			sp_q   <= in_server_present;
			sid_q  <= in_session_id;
			size_q <= eff_size;
		end
	end

	// parallel compare against every entry
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			for (int i = 0; i < N; i++) begin
				logic inr;
				inr = CNT_W'(i) < size_q;
				mc_s1[i] <= val_q[i] && inr &&
					((ch_q[i] && cfdm_q[i] == cfd_q) || (sh_q[i] && sfdm_q[i] == cfd_q));
				ms_s1[i] <= val_q[i] && inr &&
					((ch_q[i] && cfdm_q[i] == sfd_q) || (sh_q[i] && sfdm_q[i] == sfd_q));
				fr_s1[i] <= !val_q[i] && inr;
			end
			start_s1 <= ({1'b0, hint_q} < size_q) ? hint_q : '0;
		end
	end

	// encoders: highest matching id, lowest free id from the start point
	logic             hc_c, hs_c, ffa_c, ffb_c;
	logic [ID_W-1:0]  cid_c, vid_c, fa_c, fb_c;
	always_comb begin
		hc_c = 1'b0; hs_c = 1'b0; ffa_c = 1'b0; ffb_c = 1'b0;
		cid_c = '0; vid_c = '0; fa_c = '0; fb_c = '0;
		for (int i = 0; i < N; i++) begin
			if (mc_s1[i]) begin hc_c = 1'b1; cid_c = ID_W'(i); end
			if (ms_s1[i]) begin hs_c = 1'b1; vid_c = ID_W'(i); end
		end
		for (int i = N - 1; i >= 0; i--) begin
			if (fr_s1[i] && ID_W'(i) >= start_s1) begin ffa_c = 1'b1; fa_c = ID_W'(i); end
			if (fr_s1[i]) begin ffb_c = 1'b1; fb_c = ID_W'(i); end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enc) begin
			hc_s2  <= hc_c;
			hs_s2  <= hs_c;
			cid_s2 <= cid_c;
			vid_s2 <= vid_c;
			ff_s2  <= ffa_c || ffb_c;
			fid_s2 <= ffa_c ? fa_c : fb_c;
		end
	end

	assign ram_raddr = (op_q == OP_PAIR && !hc_c) ? vid_c : cid_c;

	spt_ram #(.WIDTH(2 * FD_W), .DEPTH(N)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// decision
	logic [FD_W-1:0] rd_c, rd_s;
	assign rd_c = ram_rdata[FD_W-1:0];
	assign rd_s = ram_rdata[2*FD_W-1:FD_W];

	status_t         st_d;
	logic            wr_add, wr_del, wr_srv, wr_cli;
	logic [ID_W-1:0] id_d;
	logic [FD_W-1:0] ocfd_d, osfd_d;
	logic            ocp_d, osp_d;

	always_comb begin
		st_d = ST_OK; wr_add = 1'b0; wr_del = 1'b0; wr_srv = 1'b0; wr_cli = 1'b0;
		id_d = '0; ocfd_d = '0; osfd_d = '0; ocp_d = 1'b0; osp_d = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				priority if ((!cp_q && !sp_q) || (cp_q && sp_q && cfd_q == sfd_q)) st_d = ST_BADARG;
				else if (used_q >= size_q) st_d = ST_FULL;
				else if ((cp_q && hc_s2) || (sp_q && hs_s2)) st_d = ST_INUSE;
				else if (!ff_s2) st_d = ST_FULL;
				else begin
					wr_add = 1'b1;
					id_d = fid_s2;
					ocfd_d = cp_q ? cfd_q : '0; ocp_d = cp_q;
					osfd_d = sp_q ? sfd_q : '0; osp_d = sp_q;
				end
			end
			OP_DEL: begin
				priority if ({1'b0, sid_q} >= size_q) st_d = ST_BADARG;
				else if (!val_q[sid_q]) st_d = ST_NOTFOUND;
				else begin
					wr_del = 1'b1;
					id_d = sid_q;
				end
			end
			OP_PAIR: begin
				priority if (!cp_q || !sp_q) st_d = ST_BADARG;
				else if (hc_s2) begin
					if (hs_s2) begin
						if (vid_s2 != cid_s2) st_d = ST_CONFLICT;
						else begin
							id_d = cid_s2;
							ocp_d = ch_q[cid_s2]; ocfd_d = ch_q[cid_s2] ? rd_c : '0;
							osp_d = sh_q[cid_s2]; osfd_d = sh_q[cid_s2] ? rd_s : '0;
						end
					end else if (sh_q[cid_s2]) st_d = ST_CONFLICT;
					else begin
						wr_srv = 1'b1;
						id_d = cid_s2;
						ocp_d = ch_q[cid_s2]; ocfd_d = ch_q[cid_s2] ? rd_c : '0;
						osp_d = 1'b1; osfd_d = sfd_q;
					end
				end
				else if (!hs_s2) st_d = ST_NOTFOUND;
				else if (ch_q[vid_s2]) st_d = ST_CONFLICT;
				else begin
					wr_cli = 1'b1;
					id_d = vid_s2;
					ocp_d = 1'b1; ocfd_d = cfd_q;
					osp_d = sh_q[vid_s2]; osfd_d = sh_q[vid_s2] ? rd_s : '0;
				end
			end
			OP_FIND: begin
				priority if (!cp_q) st_d = ST_BADARG;
				else if (!hc_s2) st_d = ST_NOTFOUND;
				else begin
					id_d = cid_s2;
					ocp_d = ch_q[cid_s2]; ocfd_d = ch_q[cid_s2] ? rd_c : '0;
					osp_d = sh_q[cid_s2]; osfd_d = sh_q[cid_s2] ? rd_s : '0;
				end
			end
			default: st_d = ST_BADARG;
		endcase
	end

	assign ram_we    = cmd.dec && (wr_add || wr_srv || wr_cli);
	assign ram_waddr = id_d;
	assign ram_wdata = wr_add ? {osfd_d, ocfd_d} :
		wr_srv ? {sfd_q, rd_c} : {rd_s, cfd_q};

	logic [CNT_W-1:0] nhint;
	assign nhint = {1'b0, fid_s2} + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q  <= '0;
			ch_q   <= '0;
			sh_q   <= '0;
			hint_q <= '0;
			used_q <= '0;
		end else if (cmd.dec) begin
			if (wr_add) begin
				val_q[id_d] <= 1'b1;
				ch_q[id_d]  <= cp_q;
				sh_q[id_d]  <= sp_q;
				hint_q      <= (nhint >= size_q) ? '0 : nhint[ID_W-1:0];
				used_q      <= used_q + CNT_W'(1);
			end
			if (wr_del) begin
				val_q[id_d] <= 1'b0;
				ch_q[id_d]  <= 1'b0;
				sh_q[id_d]  <= 1'b0;
				if (used_q != '0) used_q <= used_q - CNT_W'(1);
			end
			if (wr_srv) sh_q[id_d] <= 1'b1;
			if (wr_cli) ch_q[id_d] <= 1'b1;
		end
	end

	// compare copies of the handles
	always_ff @(posedge clk) begin
		if (cmd.dec) begin
			if (wr_add) begin
				cfdm_q[id_d] <= ocfd_d;
				sfdm_q[id_d] <= osfd_d;
			end
			if (wr_srv) sfdm_q[id_d] <= sfd_q;
			if (wr_cli) cfdm_q[id_d] <= cfd_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.dec) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dec) begin
			ost_q  <= st_d;
			oid_q  <= id_d;
			ocfd_q <= ocfd_d;
			ocp_q  <= ocp_d;
			osfd_q <= osfd_d;
			osp_q  <= osp_d;
		end
	end

	assign sts.out_busy       = ov_q && !out_ready;
	assign out_valid          = ov_q;
	assign out_status         = ost_q;
	assign out_id             = oid_q;
	assign out_client_fd      = ocfd_q;
	assign out_client_present = ocp_q;
	assign out_server_fd      = osfd_q;
	assign out_server_present = osp_q;
	assign out_used           = used_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(N)) else $error("entry count overflow");
	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec && wr_del |=> used_q == $past(used_q) - CNT_W'(1))
		else $error("delete did not release an entry");
	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec && wr_add |=> used_q == $past(used_q) + CNT_W'(1))
		else $error("add did not take an entry");
endmodule

// ===== rtl/session_pair_table_core.sv =====
// top level of the session pair table: controller plus datapath
// depends on spt_pkg, spt_req_if, spt_rsp_if, spt_ctrl, spt_datapath
//
// usage
// - req channel: one request per transaction (add, delete, pair, find)
// - rsp channel: exactly one result transaction per request, in order
// - cfg_we/cfg_wdata write table_size; write only while the block is idle
// - each request goes through compare (all entries in parallel), encode
//   (highest match id, rotating free-id search) and decide steps
// - a new request is taken only in the idle state, after the decide step
//   of the previous request; each request then runs the three steps
// - a finished result waits in the output register while the next
//   request is taken; the decide step holds while that register is full
//   and the receiver stalls
// - reset: all entries empty, hint and count zero, table_size 64
// - handle values sit in a ram read during the encode step, ahead of the
//   decide step, plus a flop copy for the parallel compare
module session_pair_table_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [spt_pkg::CNT_W-1:0] cfg_wdata,
	spt_req_if.sink                   req,
	spt_rsp_if.source                 rsp
);
	import spt_pkg::*;

	spt_cmd_t cmd;
	spt_sts_t sts;

	// sequencing of the three steps per transaction
	spt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table storage and result register
	spt_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.cmd                (cmd),
		.sts                (sts),
		.in_opcode          (req.opcode),
		.in_client_fd       (req.client_fd),
		.in_client_present  (req.client_present),
		.in_server_fd       (req.server_fd),
		.in_server_present  (req.server_present),
		.in_session_id      (req.session_id),
		.out_valid          (rsp.valid),
		.out_ready          (rsp.ready),
		.out_status         (rsp.status),
		.out_id             (rsp.result_id),
		.out_client_fd      (rsp.result_client_fd),
		.out_client_present (rsp.result_client_present),
		.out_server_fd      (rsp.result_server_fd),
		.out_server_present (rsp.result_server_present),
		.out_used           (rsp.entries_used)
	);
endmodule
